// ===== src/ffr_pkg.sv =====
package ffr_pkg;

  // fixed field widths
  localparam int OPW  = 13;
  localparam int ACTW = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // parameter defaults
  localparam int POSITIONS_DEF      = 4096;
  localparam int SCAN_WORD_BITS_DEF = 64;

  typedef enum logic [ACTW-1:0] {
    ACT_QUERY  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_WR,
    S_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_en;
    logic div_en;
    logic rd_en;
    logic wr_en;
    logic clr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_t act;
    logic in_rng;
    logic done;
    logic out_vld;
  } sts_t;

endpackage

// ===== src/first_fit_free_run_finder_unit.sv =====
// first-fit free-run finder
// keeps an occupancy map of positions 1..POSITIONS, held in words of
// SCAN_WORD_BITS bits with one valid flag per word
// in channel: action 0 query run of length k, 1 insert, 2 remove, 3 clear
// out channel: one run_start for each query, none for other actions
// insert/remove: reciprocal divide, read, modify-write
// clear: drops all word valid flags at once
// query: one map word per cycle through the
// memory read port; stops at the first word that holds the run
// in_tready is high only while idle and the result register is empty,
// so a stalled receiver holds off further requests
// reset leaves every position free, no clearing pass is needed
module first_fit_free_run_finder_unit #(
  parameter int POSITIONS      = ffr_pkg::POSITIONS_DEF,
  parameter int SCAN_WORD_BITS = ffr_pkg::SCAN_WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ffr_pkg::IN_TDATA_W-1:0]  in_tdata,   // action[1:0], operand[14:2]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ffr_pkg::OUT_TDATA_W-1:0] out_tdata   // run_start[12:0]
);

  ffr_pkg::cmd_t cmd;
  ffr_pkg::sts_t sts;

  ffr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffr_dp #(
    .POSITIONS      (POSITIONS),
    .SCAN_WORD_BITS (SCAN_WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== src/ffr_ctrl.sv =====
module ffr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ffr_pkg::sts_t sts,
  output ffr_pkg::cmd_t cmd
);

  ffr_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ffr_pkg::S_IDLE: begin
        in_tready = !sts.out_vld;
        if (in_tvalid && !sts.out_vld) begin
          cmd.load = 1'b1;
          unique case (sts.act)
            ffr_pkg::ACT_QUERY: begin
              cmd.scan_start = 1'b1;
              state_nxt      = ffr_pkg::S_SCAN;
            end
            ffr_pkg::ACT_INSERT, ffr_pkg::ACT_REMOVE: begin
              if (sts.in_rng) begin
                state_nxt = ffr_pkg::S_DIV;
              end
            end
            default: begin
              cmd.clr = 1'b1;
            end
          endcase
        end
      end
      ffr_pkg::S_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ffr_pkg::S_RD;
      end
      ffr_pkg::S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ffr_pkg::S_WR;
      end
      ffr_pkg::S_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = ffr_pkg::S_IDLE;
      end
      ffr_pkg::S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.done) begin
          state_nxt = ffr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ffr_dp.sv =====
module ffr_dp #(
  parameter int POSITIONS      = ffr_pkg::POSITIONS_DEF,
  parameter int SCAN_WORD_BITS = ffr_pkg::SCAN_WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ffr_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ffr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  ffr_pkg::cmd_t                    cmd,
  output ffr_pkg::sts_t                    sts
);

  localparam int W   = SCAN_WORD_BITS;
  localparam int OPW = ffr_pkg::OPW;
  localparam int MW  = (POSITIONS + W - 1) / W;
  localparam int AW  = (MW > 1) ? $clog2(MW) : 1;
  localparam int BW  = (W > 1) ? $clog2(W) : 1;
  localparam int KB  = $clog2(W + 1);
  localparam int PW  = $clog2(POSITIONS + W + 2);
  localparam int LW  = $clog2(POSITIONS + W + 1) + 1;
  localparam int SW  = LW + OPW;
  localparam int L2W = (W > 1) ? $clog2(W) : 0;
  localparam int SH  = OPW + L2W;
  localparam int RCP = (2**SH + W - 1) / W;
  localparam int PRW = SH + AW + 1;

  // input fields
  logic [OPW-1:0] operand;
  ffr_pkg::act_t  act;
  assign act     = ffr_pkg::act_t'(in_tdata[ffr_pkg::ACTW-1:0]);
  assign operand = in_tdata[ffr_pkg::ACTW +: OPW];

  // map storage with per-word valid bits
  logic [W-1:0]  mem [MW];
  logic [MW-1:0] vld_r;
  logic [W-1:0]  rdata_r;
  logic          rvld_r;
  logic [AW-1:0] raddr;

  // insert/remove operands
  logic [OPW-1:0] x_r;
  logic           set_r;
  logic [AW-1:0]  idx_r;
  logic [BW-1:0]  bit_r;
  logic [PRW-1:0] prod;
  logic [PRW-1:0] idxw;

  // scan state
  logic [OPW-1:0] k_r;
  logic [PW-1:0]  st_r;
  logic [LW-1:0]  len_r;
  logic [AW:0]    rd_idx_r;
  logic           pv_r;
  logic [PW-1:0]  pbase_r;
  logic [AW-1:0]  pidx_r;
  logic [PW-1:0]  res_r;
  logic           out_vld_r;

  logic [W-1:0]  word, free, acc, wr_word;
  logic [W-1:0]  rl [KB];
  logic [KB-1:0] lf, tf;
  logic [BW-1:0] jpos;
  logic          hit_carry, hit_in, last, done;
  logic [PW-1:0] st_nxt, ans;
  logic [LW-1:0] len_nxt;
  logic [SW-1:0] sum_lf;

  assign sts.act     = act;
  assign sts.in_rng  = (operand != '0) && (32'(operand) <= POSITIONS);
  assign sts.done    = done;
  assign sts.out_vld = out_vld_r;

  // read address and memory ports
  assign raddr = cmd.scan_en ? rd_idx_r[AW-1:0] : idx_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (cmd.wr_en) begin
      mem[idx_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (cmd.clr) begin
        vld_r <= '0;
      end else if (cmd.wr_en) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  assign word = rvld_r ? rdata_r : '0;
  assign free = ~word;

  // word index by reciprocal multiply, bit index by remainder
  assign prod = PRW'(x_r) * PRW'(RCP);
  assign idxw = PRW'(idx_r) * PRW'(W);

  always_comb begin
    wr_word = word;
    wr_word[bit_r] = set_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= operand - OPW'(1);
      set_r <= (act == ffr_pkg::ACT_INSERT);
    end
    if (cmd.div_en) begin
      idx_r <= prod[SH +: AW];
    end
    if (cmd.rd_en) begin
      bit_r <= BW'(PRW'(x_r) - idxw);
    end
  end

  // runs of 2**b free bits starting at each bit, zeros shifted in
  always_comb begin
    rl[0] = free;
    for (int b = 1; b < KB; b++) begin
      rl[b] = rl[b-1] & (rl[b-1] >> (2**(b-1)));
    end
  end

  // starts of runs of k free bits inside the word
  always_comb begin
    logic [OPW-1:0] off;
    acc = '1;
    off = '0;
    for (int b = 0; b < KB; b++) begin
      if (k_r[b]) begin
        acc = acc & (rl[b] >> off);
        off = off + OPW'(2**b);
      end
    end
    if (32'(k_r) > W) begin
      acc = '0;
    end
  end

  // leading free, trailing free, first run start
  always_comb begin
    lf   = KB'(W);
    tf   = KB'(W);
    jpos = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (word[i]) lf = KB'(i);
      if (acc[i])  jpos = BW'(i);
    end
    for (int i = 0; i < W; i++) begin
      if (word[i]) tf = KB'(W - 1 - i);
    end
  end

  assign sum_lf    = SW'(len_r) + SW'(lf);
  assign hit_carry = sum_lf >= SW'(k_r);
  assign hit_in    = |acc;
  assign last      = (pidx_r == AW'(MW - 1));
  assign done      = cmd.scan_en && pv_r && (hit_carry || hit_in || last);

  always_comb begin
    if (word == '0) begin
      st_nxt  = st_r;
      len_nxt = len_r + LW'(W);
    end else begin
      st_nxt  = pbase_r + PW'(W) - PW'(tf) + PW'(1);
      len_nxt = LW'(tf);
    end
    if (hit_carry) begin
      ans = st_r;
    end else if (hit_in) begin
      ans = pbase_r + PW'(jpos) + PW'(1);
    end else begin
      ans = st_nxt;
    end
  end

  // scan sequencing, one word per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (cmd.scan_start) begin
      pv_r <= 1'b0;
    end else if (cmd.scan_en) begin
      pv_r <= (32'(rd_idx_r) < MW);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      k_r      <= operand;
      st_r     <= PW'(1);
      len_r    <= '0;
      rd_idx_r <= '0;
      pbase_r  <= '0;
    end else if (cmd.scan_en) begin
      pidx_r <= rd_idx_r[AW-1:0];
      if (32'(rd_idx_r) < MW) begin
        rd_idx_r <= rd_idx_r + (AW+1)'(1);
      end
      if (pv_r) begin
        st_r    <= st_nxt;
        len_r   <= len_nxt;
        pbase_r <= pbase_r + PW'(W);
      end
    end
    if (done) begin
      res_r <= ans;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (done) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  logic [PW+OPW-1:0] res_ext;
  assign res_ext    = {{OPW{1'b0}}, res_r};
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(ffr_pkg::OUT_TDATA_W-OPW){1'b0}}, res_ext[OPW-1:0]};

`ifndef SYNTHESIS
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> $past(cmd.rd_en))
    else $error("map write without preceding read");
  a_ans_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ans != '0)
    else $error("run start of zero");
  a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |=> vld_r == '0)
    else $error("map not empty after clear");
  a_done_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !out_vld_r)
    else $error("result overwrites pending result");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOS = ffr_pkg::POSITIONS_DEF;
  localparam int N_RANDOM = 1530;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ffr_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ffr_pkg::OUT_TDATA_W-1:0] out_tdata;

  // occupancy shadow, index 0 unused
  bit occ_shadow [NPOS+1];
  logic [ffr_pkg::OPW-1:0] run_start_q[$];
  int fail_cnt = 0;
  bit calm = 1'b0;

  typedef struct {
    ffr_pkg::act_t act;
    logic [ffr_pkg::OPW-1:0] operand;
    bit has_fixed;
    logic [ffr_pkg::OPW-1:0] fixed_start;
  } stim_row_t;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  first_fit_free_run_finder_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // first-fit search over the shadow map
  function automatic logic [ffr_pkg::OPW-1:0] first_fit_start(logic [ffr_pkg::OPW-1:0] k);
    int start;
    int len;
    start = 1;
    len = 0;
    if (k == 0) return ffr_pkg::OPW'(1);
    for (int p = 1; p <= NPOS; p++) begin
      if (occ_shadow[p]) begin
        len = 0;
        start = p + 1;
      end else begin
        len++;
        if (len >= k) return start[ffr_pkg::OPW-1:0];
      end
    end
    return start[ffr_pkg::OPW-1:0];
  endfunction

  // update shadow and queue expected start for one accepted request
  task automatic predict(ffr_pkg::act_t act, logic [ffr_pkg::OPW-1:0] operand,
                         bit has_fixed, logic [ffr_pkg::OPW-1:0] fixed_start);
    logic [ffr_pkg::OPW-1:0] guess;
    case (act)
      ffr_pkg::ACT_QUERY: begin
        guess = first_fit_start(operand);
        if (has_fixed && guess != fixed_start) begin
          $error("predictor run_start expected %0d got %0d", fixed_start, guess);
          fail_cnt++;
        end
        run_start_q = {run_start_q, (has_fixed ? fixed_start : guess)};
      end
      ffr_pkg::ACT_INSERT: if (operand >= 1 && operand <= NPOS) occ_shadow[operand] = 1'b1;
      ffr_pkg::ACT_REMOVE: if (operand >= 1 && operand <= NPOS) occ_shadow[operand] = 1'b0;
      default: foreach (occ_shadow[i]) occ_shadow[i] = 1'b0;
    endcase
  endtask

  // send one request, with random idle cycles before it unless calm is set
  task automatic send(ffr_pkg::act_t act, logic [ffr_pkg::OPW-1:0] operand,
                      bit has_fixed = 0, logic [ffr_pkg::OPW-1:0] fixed_start = '0);
    while (!calm && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, operand, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict(act, operand, has_fixed, fixed_start);
  endtask

  // receiver with random stalls unless calm is set
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (run_start_q.size() == 0) begin
          $error("run_start unexpected result %0d", out_tdata[ffr_pkg::OPW-1:0]);
          fail_cnt++;
        end else begin
          if (out_tdata[ffr_pkg::OPW-1:0] !== run_start_q[0]) begin
            $error("run_start expected %0d actual %0d", run_start_q[0],
                   out_tdata[ffr_pkg::OPW-1:0]);
            fail_cnt++;
          end
          void'(run_start_q.pop_front());
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  function automatic logic [ffr_pkg::OPW-1:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return ffr_pkg::OPW'($urandom_range(8));
    if (r < 80) return ffr_pkg::OPW'($urandom_range(128));
    if (r < 95) return ffr_pkg::OPW'($urandom_range(4097));
    return ffr_pkg::OPW'($urandom);
  endfunction

  function automatic logic [ffr_pkg::OPW-1:0] rand_pos(int lim);
    int r;
    r = $urandom_range(99);
    if (r < 70) return ffr_pkg::OPW'($urandom_range(lim, 1));
    if (r < 90) return ffr_pkg::OPW'($urandom_range(NPOS, 1));
    if (r < 95) return '0;
    return ffr_pkg::OPW'($urandom);
  endfunction

  initial begin
    stim_row_t rows[$];
    int lim;
    int r;
    rows = '{
      '{ffr_pkg::ACT_QUERY,  13'd0,    1, 13'd1},
      '{ffr_pkg::ACT_QUERY,  13'd1,    1, 13'd1},
      '{ffr_pkg::ACT_QUERY,  13'd4096, 1, 13'd1},
      '{ffr_pkg::ACT_QUERY,  13'd8191, 1, 13'd1},
      '{ffr_pkg::ACT_INSERT, 13'd1,    0, 13'd0},
      '{ffr_pkg::ACT_QUERY,  13'd1,    1, 13'd2},
      '{ffr_pkg::ACT_INSERT, 13'd4096, 0, 13'd0},
      '{ffr_pkg::ACT_QUERY,  13'd4095, 1, 13'd4097},
      '{ffr_pkg::ACT_QUERY,  13'd4094, 1, 13'd2},
      '{ffr_pkg::ACT_INSERT, 13'd0,    0, 13'd0},
      '{ffr_pkg::ACT_INSERT, 13'd4097, 0, 13'd0},
      '{ffr_pkg::ACT_INSERT, 13'd8191, 0, 13'd0},
      '{ffr_pkg::ACT_INSERT, 13'd64,   0, 13'd0},
      '{ffr_pkg::ACT_INSERT, 13'd64,   0, 13'd0},
      '{ffr_pkg::ACT_QUERY,  13'd63,   1, 13'd65},
      '{ffr_pkg::ACT_REMOVE, 13'd64,   0, 13'd0},
      '{ffr_pkg::ACT_REMOVE, 13'd64,   0, 13'd0},
      '{ffr_pkg::ACT_REMOVE, 13'd0,    0, 13'd0},
      '{ffr_pkg::ACT_QUERY,  13'd63,   0, 13'd0},
      '{ffr_pkg::ACT_REMOVE, 13'd1,    0, 13'd0},
      '{ffr_pkg::ACT_QUERY,  13'd4095, 1, 13'd1},
      '{ffr_pkg::ACT_CLEAR,  13'd8191, 0, 13'd0},
      '{ffr_pkg::ACT_QUERY,  13'd4096, 1, 13'd1},
      '{ffr_pkg::ACT_INSERT, 13'd2048, 0, 13'd0},
      '{ffr_pkg::ACT_QUERY,  13'd3000, 1, 13'd2049}
    };
    foreach (occ_shadow[i]) occ_shadow[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].act, rows[i].operand, rows[i].has_fixed,
                           rows[i].fixed_start);

    // random part: queries mixed with inserts and removes aimed mostly at a region, rare clears
    lim = 128;
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 750);
      if (n % 200 == 0) lim = ($urandom_range(3) == 0) ? NPOS : $urandom_range(200, 16);
      r = $urandom_range(99);
      if (r < 40)      send(ffr_pkg::ACT_QUERY, rand_len());
      else if (r < 75) send(ffr_pkg::ACT_INSERT, rand_pos(lim));
      else if (r < 98) send(ffr_pkg::ACT_REMOVE, rand_pos(lim));
      else             send(ffr_pkg::ACT_CLEAR, ffr_pkg::OPW'($urandom));
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (run_start_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && run_start_q.size() == 0)
      $display("first_fit_free_run_finder_unit: match");
    else
      $display("first_fit_free_run_finder_unit: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("first_fit_free_run_finder_unit: mismatch");
    $finish;
  end

endmodule

// ===== first_fit_free_run_finder_unit.f =====
src/ffr_pkg.sv
src/ffr_ctrl.sv
src/ffr_dp.sv
src/first_fit_free_run_finder_unit.sv
sim/testbench.sv
